// File: hdl/qpht_pkg.sv
// Shared types and constants of the quadratic-probing hash table.
`default_nettype none

package qpht_pkg;

    // Widths fixed by the request and result formats
    localparam int KEY_W   = 16;
    localparam int SIZE_W  = 5;
    localparam int SLOT_W  = 4;
    localparam int STAT_W  = 3;

    // Register reset value of table_size
    localparam int SIZE_RESET = 11;

    // Home slot is key mod 10: quotient by reciprocal, exact for 16-bit keys
    localparam logic [16:0] DIV10_MUL   = 17'd52429;
    localparam int          DIV10_SHIFT = 19;
    localparam int          QUOT_W      = 13;

    // Operation codes
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_SEARCH = 1'b1;

    // Status codes
    localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STAT_W-1:0] ST_REFUSED   = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STAT_W-1:0] ST_FOUND     = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd4;

    typedef struct packed {
        logic              func;
        logic [KEY_W-1:0]  key;
    } t_req;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [SLOT_W-1:0] slot;
        logic [SIZE_W-1:0] stored_count;
    } t_res;

    // Commands from the probe sequencer to the slot store
    typedef struct packed {
        logic clr;
        logic wr;
    } t_store_cmd;

endpackage

`default_nettype wire

// File: hdl/quadratic_probe_hash_table.sv
// Top level of the open-addressing hash table with quadratic probing.
// Steps: accept, the key/10 quotient, the home slot (a refused insert goes straight to the result),
//   subtractions reducing home mod size (none when size >= 10), issue of the first probe,
//   the probes (1 to size), then the result register.
// Throughput: one request at a time; the next is taken once the result has moved to the
//   output register. The probe loop does one key-memory read per cycle and sets the rate.
// Reset (synchronous, active low): table_size 11, all slots empty, count zero; no sweep.
`default_nettype none

module quadratic_probe_hash_table #(
    parameter int TABLE_DEPTH = 16,
    parameter int KEY_BITS    = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // Request channel
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire qpht_pkg::t_req                     i_in_req,
    // Result channel
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output qpht_pkg::t_res                          o_out_res,
    // table_size write channel
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [qpht_pkg::SIZE_W-1:0]        i_cfg_data
);

    // table_size is five bits, so no more than 31 slots are ever addressed
    localparam int NV = (TABLE_DEPTH < 31) ? TABLE_DEPTH : 31;
    localparam int AW = (NV > 1) ? $clog2(NV) : 1;
    localparam int KW = (KEY_BITS < qpht_pkg::KEY_W) ? KEY_BITS : qpht_pkg::KEY_W;
    localparam int SW = qpht_pkg::SIZE_W;
    localparam logic [SW-1:0] SIZE_RST =
        SW'((qpht_pkg::SIZE_RESET > NV) ? NV : qpht_pkg::SIZE_RESET);
    localparam logic [SW-1:0] SIZE_MAX = SW'(NV);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_DIV   = 6'b000010,
        S_HOME  = 6'b000100,
        S_MOD   = 6'b001000,
        S_PROBE = 6'b010000,
        S_PUSH  = 6'b100000
    } t_state;

    t_state                          r_state, n_state;
    logic                            r_func, n_func;
    logic [qpht_pkg::KEY_W-1:0]      r_key, n_key;
    logic [qpht_pkg::QUOT_W-1:0]     r_quot, n_quot;
    logic [SW-1:0]                   r_pos, n_pos;     // next probe position
    logic [SW-1:0]                   r_inc, n_inc;     // (2i+1) mod size
    logic [SW-1:0]                   r_addr, n_addr;   // position of the probe in flight
    logic [SW-1:0]                   r_cnt, n_cnt;     // probes issued
    logic [SW-1:0]                   r_count, n_count; // stored keys
    logic [SW-1:0]                   r_size, n_size;   // effective table size
    qpht_pkg::t_res                  r_res, n_res;
    qpht_pkg::t_res                  r_out, n_out;
    logic                            r_out_valid, n_out_valid;

    logic [qpht_pkg::KEY_W-1:0]      key_m;
    logic [32:0]                     prod;
    logic [qpht_pkg::KEY_W-1:0]      rem;
    logic [SW-1:0]                   cfg_size;
    logic [SW:0]                     pos_sum;
    logic [SW:0]                     inc_a;
    logic [SW:0]                     inc_b;
    logic [SW-1:0]                   nxt_pos;
    logic [SW-1:0]                   nxt_inc;
    logic                            cfg_we;
    logic                            push;
    logic                            exhausted;
    logic                            hit;
    qpht_pkg::t_store_cmd            st_cmd;
    logic [KEY_BITS-1:0]             rd_key;
    logic                            rd_valid;

    // Mask the key down to the stored key width
    always_comb begin
        for (int b = 0; b < qpht_pkg::KEY_W; b++) begin
            key_m[b] = i_in_req.key[b] & (b < KW);
        end
    end

    // key / 10 by reciprocal; the remainder follows from shifts, one add and one subtract
    assign prod = 33'(r_key) * 33'(qpht_pkg::DIV10_MUL);
    assign rem  = r_key - (qpht_pkg::KEY_W'({r_quot, 3'b000})
                         + qpht_pkg::KEY_W'({r_quot, 1'b0}));

    // Clamp written size: zero acts as one, anything above the store depth as the depth
    assign cfg_size = (i_cfg_data == '0) ? SW'(1)
                    : (i_cfg_data > SIZE_MAX) ? SIZE_MAX : i_cfg_data;

    // Quadratic step: pos += 2i+1, then the odd increment grows by two, both mod size
    assign pos_sum = {1'b0, r_pos} + {1'b0, r_inc};
    assign nxt_pos = (pos_sum >= {1'b0, r_size}) ? SW'(pos_sum - {1'b0, r_size})
                                                 : SW'(pos_sum);
    assign inc_a   = {1'b0, r_inc} + (SW+1)'(2);
    assign inc_b   = (inc_a >= {1'b0, r_size}) ? inc_a - {1'b0, r_size} : inc_a;
    assign nxt_inc = (inc_b >= {1'b0, r_size}) ? SW'(inc_b - {1'b0, r_size})
                                               : SW'(inc_b);

    assign cfg_we    = i_cfg_valid && o_cfg_ready;
    assign push      = (r_state == S_PUSH) && (!r_out_valid || !i_out_stall);
    assign exhausted = (r_cnt == r_size);
    assign hit       = rd_valid && (rd_key == KEY_BITS'(r_key));

    always_comb begin
        n_state     = r_state;
        n_func      = r_func;
        n_key       = r_key;
        n_quot      = r_quot;
        n_pos       = r_pos;
        n_inc       = r_inc;
        n_addr      = r_addr;
        n_cnt       = r_cnt;
        n_count     = r_count;
        n_size      = r_size;
        n_res       = r_res;
        st_cmd.clr  = cfg_we;
        st_cmd.wr   = 1'b0;

        // A size write empties the table
        if (cfg_we) begin
            n_size  = cfg_size;
            n_count = '0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_func  = i_in_req.func;
                    n_key   = key_m;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_quot  = prod[qpht_pkg::DIV10_SHIFT +: qpht_pkg::QUOT_W];
                n_state = S_HOME;
            end
            S_HOME: begin
                // Load limit: refuse when count * 2 exceeds the size
                if (r_func == qpht_pkg::FUNC_INSERT
                        && {r_count, 1'b0} > {1'b0, r_size}) begin
                    n_res.status       = qpht_pkg::ST_REFUSED;
                    n_res.slot         = '0;
                    n_res.stored_count = r_count;
                    n_state            = S_PUSH;
                end else begin
                    n_pos   = SW'(rem[3:0]);
                    n_inc   = (r_size == SW'(1)) ? '0 : SW'(1);
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                // Reduce the home slot below the size, then issue the first probe
                if (r_pos >= r_size) begin
                    n_pos = r_pos - r_size;
                end else begin
                    n_addr  = r_pos;
                    n_pos   = nxt_pos;
                    n_inc   = nxt_inc;
                    n_cnt   = SW'(1);
                    n_state = S_PROBE;
                end
            end
            S_PROBE: begin
                // Judge the returned slot; issue the next probe in the same cycle
                n_res.slot         = '0;
                n_res.stored_count = r_count;
                if (r_func == qpht_pkg::FUNC_INSERT) begin
                    if (!rd_valid) begin
                        st_cmd.wr          = 1'b1;
                        n_count            = r_count + SW'(1);
                        n_res.status       = qpht_pkg::ST_INSERTED;
                        n_res.slot         = r_addr[qpht_pkg::SLOT_W-1:0];
                        n_res.stored_count = r_count + SW'(1);
                        n_state            = S_PUSH;
                    end else if (exhausted) begin
                        n_res.status = qpht_pkg::ST_FULL;
                        n_state      = S_PUSH;
                    end
                end else begin
                    if (hit) begin
                        n_res.status = qpht_pkg::ST_FOUND;
                        n_res.slot   = r_addr[qpht_pkg::SLOT_W-1:0];
                        n_state      = S_PUSH;
                    end else if (!rd_valid || exhausted) begin
                        n_res.status = qpht_pkg::ST_NOT_FOUND;
                        n_state      = S_PUSH;
                    end
                end
                if (n_state == S_PROBE) begin
                    n_addr = r_pos;
                    n_pos  = nxt_pos;
                    n_inc  = nxt_inc;
                    n_cnt  = r_cnt + SW'(1);
                end
            end
            S_PUSH: begin
                if (push) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output register: load from the result hold, drop once taken
    assign n_out_valid = push || (r_out_valid && i_out_stall);
    assign n_out       = push ? r_res : r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_size      <= SIZE_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_size      <= n_size;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func <= n_func;
        r_key  <= n_key;
        r_quot <= n_quot;
        r_pos  <= n_pos;
        r_inc  <= n_inc;
        r_addr <= n_addr;
        r_cnt  <= n_cnt;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    // Probe reads run every cycle at the next probe position; writes only end an insert,
    // so no probe of the same request can see a stale entry
    qpht_store #(
        .NV       (NV),
        .AW       (AW),
        .KEY_BITS (KEY_BITS)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (st_cmd),
        .i_waddr    (AW'(r_addr)),
        .i_wkey     (KEY_BITS'(r_key)),
        .i_raddr    (AW'(r_pos)),
        .o_rd_key   (rd_key),
        .o_rd_valid (rd_valid)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out;

    // Stored count never exceeds the table size
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_size)
        else $error("stored count above table size");

    // Probe positions stay inside the table
    a_probe_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE) |-> (r_addr < r_size && r_pos < r_size))
        else $error("probe position out of range");

    // Never more probes than slots
    a_probe_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE) |-> (r_cnt != '0 && r_cnt <= r_size))
        else $error("probe count out of range");

    // A store write raises the count by one
    a_write_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st_cmd.wr |=> (r_count == $past(r_count) + SW'(1)))
        else $error("count not advanced on insert");

endmodule

`default_nettype wire

// File: hdl/qpht_store.sv
// Slot store: key memory with a registered read, and valid marks in flip-flops.
`default_nettype none

module qpht_store #(
    parameter int NV       = 16,
    parameter int AW       = 4,
    parameter int KEY_BITS = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire qpht_pkg::t_store_cmd   i_cmd,
    input  wire logic [AW-1:0]          i_waddr,
    input  wire logic [KEY_BITS-1:0]    i_wkey,
    input  wire logic [AW-1:0]          i_raddr,
    output logic      [KEY_BITS-1:0]    o_rd_key,
    output logic                        o_rd_valid
);

    logic [KEY_BITS-1:0] mem [NV];
    logic [NV-1:0]       r_valid;
    logic [KEY_BITS-1:0] r_rd_key;
    logic                r_rd_valid;

    // Key memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            mem[i_waddr] <= i_wkey;
        end
        r_rd_key <= mem[i_raddr];
    end

    // Valid marks: drop all on reset or clear, set on write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr) begin
            r_valid <= '0;
        end else if (i_cmd.wr) begin
            r_valid[i_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= r_valid[i_raddr];
        end
    end

    assign o_rd_key   = r_rd_key;
    assign o_rd_valid = r_rd_valid;

endmodule

`default_nettype wire

// File: tb/qpht_checker.sv
// Checker for the quadratic-probing hash table: predicts each result and compares it.
`timescale 1ns / 100ps

module qpht_checker #(
    parameter int TABLE_DEPTH = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    input  wire logic                        i_in_stall,
    input  wire qpht_pkg::t_req              i_in_req,
    input  wire logic                        i_out_valid,
    input  wire logic                        i_out_stall,
    input  wire qpht_pkg::t_res              i_out_res,
    input  wire logic                        i_cfg_valid,
    input  wire logic                        i_cfg_ready,
    input  wire logic [qpht_pkg::SIZE_W-1:0] i_cfg_data,
    output int                               o_fail_count,
    output int                               o_pending
);

    localparam int HOME_MODULUS = 10;

    logic [qpht_pkg::KEY_W-1:0]  shadow_key  [TABLE_DEPTH];
    logic                        shadow_used [TABLE_DEPTH];
    int                          shadow_count;
    logic [qpht_pkg::SIZE_W-1:0] size_setting;
    qpht_pkg::t_res              expected_res_q [$];
    int                          mismatches;

    task automatic empty_table();
        foreach (shadow_used[s]) shadow_used[s] = 1'b0;
        shadow_count = 0;
    endtask

    // Apply one request to the shadow table and return the result it gives.
    function automatic qpht_pkg::t_res apply_request(input qpht_pkg::t_req r);
        int             size;
        int             home;
        int             p;
        qpht_pkg::t_res res;
        size = (size_setting == 0) ? 1 :
               (size_setting > TABLE_DEPTH) ? TABLE_DEPTH : int'(size_setting);
        home = int'(r.key % HOME_MODULUS);
        res.slot = '0;
        if (r.func == qpht_pkg::FUNC_INSERT) begin
            if (shadow_count * 2 > size) begin
                res.status = qpht_pkg::ST_REFUSED;
            end else begin
                res.status = qpht_pkg::ST_FULL;
                for (int i = 0; i < size; i++) begin
                    p = (home + i * i) % size;
                    if (!shadow_used[p]) begin
                        shadow_key[p]  = r.key;
                        shadow_used[p] = 1'b1;
                        shadow_count++;
                        res.status = qpht_pkg::ST_INSERTED;
                        res.slot   = p[qpht_pkg::SLOT_W-1:0];
                        break;
                    end
                end
            end
        end else begin
            res.status = qpht_pkg::ST_NOT_FOUND;
            for (int i = 0; i < size; i++) begin
                p = (home + i * i) % size;
                if (!shadow_used[p]) break;
                if (shadow_key[p] == r.key) begin
                    res.status = qpht_pkg::ST_FOUND;
                    res.slot   = p[qpht_pkg::SLOT_W-1:0];
                    break;
                end
            end
        end
        res.stored_count = shadow_count[qpht_pkg::SIZE_W-1:0];
        return res;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin : monitor
        qpht_pkg::t_res want;
        if (!i_rst_n) begin
            size_setting = qpht_pkg::SIZE_W'(qpht_pkg::SIZE_RESET);
            empty_table();
            expected_res_q.delete();
            mismatches = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_res_q.size() == 0) begin
                    $error("unexpected result: status %0d slot %0d stored_count %0d",
                           i_out_res.status, i_out_res.slot, i_out_res.stored_count);
                    mismatches++;
                end else begin
                    want = expected_res_q.pop_front();
                    check_field("status", want.status, i_out_res.status);
                    check_field("slot", want.slot, i_out_res.slot);
                    check_field("stored_count", want.stored_count, i_out_res.stored_count);
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_res_q.push_back(apply_request(i_in_req));
            // a size write empties the table
            if (i_cfg_valid && i_cfg_ready) begin
                size_setting = i_cfg_data;
                empty_table();
            end
        end
        o_pending    <= expected_res_q.size();
        o_fail_count <= mismatches;
    end

endmodule

// File: tb/tb_quadratic_probe_hash_table.sv
// Testbench top for the quadratic-probing hash table: stimulus, watchdog and verdict.
`timescale 1ns / 100ps

module tb_quadratic_probe_hash_table;

    // Phase plan: 40 table sizes of 30 requests each after the directed part
    localparam int PHASES          = 40;
    localparam int REQS_PER_PHASE  = 30;
    localparam int POOL_KEYS       = 8;
    // Longest item is the quotient, home-slot and result steps + 9 mod-reduction steps + 16 probes
    localparam int SETTLE_CYCLES   = 40;
    localparam int HOLD_OFF_CYCLES = 250;
    localparam int QUIET_LIMIT     = 2000;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_in_valid;
    logic                          o_in_stall;
    qpht_pkg::t_req                i_in_req;
    logic                          o_out_valid;
    logic                          i_out_stall;
    qpht_pkg::t_res                o_out_res;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [qpht_pkg::SIZE_W-1:0]   i_cfg_data;

    int                  fail_count;
    int                  pending;
    int                  quiet_cycles;
    int                  tx_gap_pct;
    int                  rx_stall_pct;
    logic                hold_off_req;

    // Idling modes: none, sender only, receiver only, both
    int gap_pct_tab   [4] = '{0, 49, 0, 27};
    int stall_pct_tab [4] = '{0, 0, 49, 27};

    // Sizes for the random phases: extremes first, then random settings
    logic [qpht_pkg::SIZE_W-1:0] size_plan [12] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd2, 5'd3,
                                                    5'd11, 5'd17, 5'd5, 5'd10, 5'd8, 5'd15};

    quadratic_probe_hash_table dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_res   (o_out_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    qpht_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_req     (i_in_req),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_res    (o_out_res),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Receiver: stall at the current rate; on request, hold off for a long
    // stretch so the block backs up and stalls its request side.
    initial begin : receiver
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end
            i_out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
        end
    end

    // Watchdog: count cycles in which no channel moves anything.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin : watchdog
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("simulation failed");
        $finish;
    end

    // Offer one request after a random gap and hold it until accepted. Valid
    // stays high on return, so a following request drawn with no gap goes straight out.
    task automatic send_request(input logic op, input logic [qpht_pkg::KEY_W-1:0] key);
        while ($urandom_range(0, 99) < tx_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_in_req.func <= op;
        i_in_req.key  <= key;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // Drop valid and wait until every outstanding request has its result.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Drain, let the block settle, then write table_size (this clears the table).
    task automatic resize_table(input logic [qpht_pkg::SIZE_W-1:0] size);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= size;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        logic [qpht_pkg::KEY_W-1:0] key_pool [POOL_KEYS];
        int                         home;
        logic [qpht_pkg::KEY_W-1:0] key;

        hold_off_req = 1'b0;
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_req    <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset size 11: key extremes, collisions on home slot 0, load limit
        send_request(qpht_pkg::FUNC_INSERT, 16'd0);
        send_request(qpht_pkg::FUNC_INSERT, 16'hFFFF);
        send_request(qpht_pkg::FUNC_SEARCH, 16'hFFFF);
        send_request(qpht_pkg::FUNC_SEARCH, 16'd0);
        send_request(qpht_pkg::FUNC_SEARCH, 16'd12345);     // home slot taken by another key
        send_request(qpht_pkg::FUNC_INSERT, 16'd10);
        send_request(qpht_pkg::FUNC_INSERT, 16'd20);
        send_request(qpht_pkg::FUNC_INSERT, 16'd30);
        send_request(qpht_pkg::FUNC_INSERT, 16'd40);
        send_request(qpht_pkg::FUNC_INSERT, 16'd50);        // refused by the load limit
        send_request(qpht_pkg::FUNC_SEARCH, 16'd40);
        send_request(qpht_pkg::FUNC_SEARCH, 16'd50);

        // One slot: search runs out of probes with no empty slot seen
        resize_table(5'd1);
        send_request(qpht_pkg::FUNC_INSERT, 16'd7);
        send_request(qpht_pkg::FUNC_INSERT, 16'd8);
        send_request(qpht_pkg::FUNC_SEARCH, 16'd8);
        send_request(qpht_pkg::FUNC_SEARCH, 16'd7);

        // Sixteen slots: stale key after clearing, then home 0 only reaches
        // slots 0, 1, 4 and 9, so the fifth insert finds no free slot
        resize_table(5'd16);
        send_request(qpht_pkg::FUNC_SEARCH, 16'd7);
        send_request(qpht_pkg::FUNC_INSERT, 16'd0);
        send_request(qpht_pkg::FUNC_INSERT, 16'd10);
        send_request(qpht_pkg::FUNC_INSERT, 16'd20);
        send_request(qpht_pkg::FUNC_INSERT, 16'd30);
        send_request(qpht_pkg::FUNC_INSERT, 16'd40);
        send_request(qpht_pkg::FUNC_SEARCH, 16'd40);
        send_request(qpht_pkg::FUNC_SEARCH, 16'd30);

        // Random phases: mostly keys from a small pool whose first five keys share one home
        // slot, so inserts collide and searches hit; the rest is noise.
        for (int ph = 0; ph < PHASES; ph++) begin
            resize_table(ph < 12 ? size_plan[ph]
                                 : qpht_pkg::SIZE_W'($urandom_range(0, 31)));
            tx_gap_pct   = gap_pct_tab[ph % 4];
            rx_stall_pct = stall_pct_tab[ph % 4];
            home = $urandom_range(0, 9);
            foreach (key_pool[j])
                key_pool[j] = (j < 5)
                    ? qpht_pkg::KEY_W'(home + 10 * $urandom_range(0, 6552))
                    : qpht_pkg::KEY_W'($urandom_range(0, 65535));
            // long receiver hold-off while requests keep coming
            if (ph == 4 || ph == 21)
                hold_off_req = 1'b1;
            for (int n = 0; n < REQS_PER_PHASE; n++) begin
                // pause now and then until every result is back
                if (n == REQS_PER_PHASE / 2 && ph % 5 == 2)
                    drain_results();
                if ($urandom_range(0, 99) < 80)
                    key = key_pool[$urandom_range(0, POOL_KEYS - 1)];
                else
                    key = qpht_pkg::KEY_W'($urandom_range(0, 65535));
                send_request($urandom_range(0, 1) ? qpht_pkg::FUNC_SEARCH
                                                  : qpht_pkg::FUNC_INSERT, key);
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// File: filelist.f
hdl/qpht_pkg.sv
hdl/qpht_store.sv
hdl/quadratic_probe_hash_table.sv
tb/qpht_checker.sv
tb/tb_quadratic_probe_hash_table.sv
